### rtl/core/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

   localparam int NUM_WIDTH_DEF = 16;

   typedef struct packed {
      logic done;
      logic zero;
   } ptd_div_stat_type;

endpackage

### rtl/core/ptd_req_if.sv
`timescale 1ns / 1ps

interface ptd_req_if #(
   parameter int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic [NUM_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);
endinterface

### rtl/core/ptd_rsp_if.sv
`timescale 1ns / 1ps

interface ptd_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

### rtl/core/ptd_rem_unit.sv
`timescale 1ns / 1ps

// restoring remainder, one dividend bit per cycle
module ptd_rem_unit #(
   parameter int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_WIDTH-1:0]          dividend,
   input  logic [(NUM_WIDTH+1)/2+1:0]    divisor,
   output ptd_pkg::ptd_div_stat_type     stat
);
   localparam int DW = (NUM_WIDTH + 1) / 2 + 2;
   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [NUM_WIDTH-1:0] sh_ff, sh_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   assign trial = {rem_ff, sh_ff[NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_WIDTH);
         rem_in  = '0;
         div_in  = divisor;
         sh_in   = dividend;
      end else if (busy_ff) begin
         rem_in = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
         sh_in  = {sh_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      sh_ff  <= sh_in;
   end

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);
endmodule

### rtl/core/prime_trial_division.sv
`timescale 1ns / 1ps
// Numbers 0..3 and even numbers go from accept straight to the result.
// Otherwise odd trial divisors 3, 5, 7, ... are tried up to the square root,
// each by the bit-serial remainder unit. One word in flight: a new number is
// accepted only once the last result has been loaded into the response register.
// Synchronous active-high reset clears the sequencer and the result valid.
module prime_trial_division #(
   parameter int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
   input logic           clock,
   input logic           reset,
   ptd_req_if.sink       req_chan,
   ptd_rsp_if.source     rsp_chan
);
   localparam int DW = (NUM_WIDTH + 1) / 2 + 2;
   localparam int SW = NUM_WIDTH + 2;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_TEST   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [SW-1:0]        sq_ff, sq_in;
   logic                 res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_prime_ff, rsp_prime_in;
   logic                 div_start;
   logic                 slot_free;
   ptd_pkg::ptd_div_stat_type div_stat;

   ptd_rem_unit #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .stat     (div_stat)
   );

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.is_prime = rsp_prime_ff;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      res_in       = res_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_prime_in = rsp_prime_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               n_in  = req_chan.number;
               d_in  = DW'(3);
               sq_in = SW'(9);
               if (req_chan.number < NUM_WIDTH'(2)) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else if (req_chan.number < NUM_WIDTH'(4)) begin
                  res_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (!req_chan.number[0]) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            if (sq_ff > SW'(n_ff)) begin
               res_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (div_stat.zero) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // (d+2)^2 = d^2 + 4d + 4
                  d_in     = d_ff + DW'(2);
                  sq_in    = sq_ff + SW'({d_ff, 2'b00}) + SW'(4);
                  state_in = ST_TEST;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      res_ff       <= res_in;
      rsp_prime_ff <= rsp_prime_in;
   end
endmodule

### tb/prime_trial_division_test.sv
`timescale 1ns / 1ps

module prime_trial_division_test;

   localparam int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 2600;

   typedef logic [NUM_WIDTH-1:0] number_type;

   typedef struct {
      number_type number;
      logic       is_prime;
   } prime_verdict_type;

   logic clock;
   logic reset;

   ptd_req_if #(.NUM_WIDTH(NUM_WIDTH)) req_chan ();
   ptd_rsp_if rsp_chan ();

   prime_trial_division #(.NUM_WIDTH(NUM_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   prime_verdict_type verdicts_due[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                burst_left = 0;
   bit                sender_gaps = 1'b1;
   bit                receiver_stalls = 1'b1;
   logic [5:0]        stall_phase = '0;
   logic [15:0]       stall_pattern = '1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("prime_trial_division_test: errors");
         $finish;
      end
   end

   // trial division, odd and even divisors alike, up to the square root
   function automatic logic prime_flag(number_type value);
      longint unsigned n;
      longint unsigned d;
      n = 64'(value);
      if (n < 2) return 1'b0;
      for (d = 64'd2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // receiver: new 16-bit ready pattern each time the 6-bit phase counter wraps
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == '0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= '1;
            1: stall_pattern <= 16'($urandom);
            2: stall_pattern <= 16'($urandom | $urandom);
            default: stall_pattern <= 16'($urandom & $urandom) | 16'h0001;
         endcase
      end
      rsp_chan.ready <= receiver_stalls ? stall_pattern[stall_phase[3:0]] : 1'b1;
   end

   always @(posedge clock) begin
      prime_verdict_type due;
      if (!reset && req_chan.valid && req_chan.ready) begin
         due.number = req_chan.number;
         due.is_prime = prime_flag(req_chan.number);
         verdicts_due.insert(verdicts_due.size(), due);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word, is_prime %b", rsp_chan.is_prime));
         end else begin
            due = verdicts_due.pop_front();
            if (rsp_chan.is_prime !== due.is_prime)
               report_mismatch($sformatf("number %0d: is_prime %b, want %b",
                  due.number, rsp_chan.is_prime, due.is_prime));
         end
      end
   end

   task automatic send_word(input number_type value);
      if (sender_gaps && burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_chan.valid <= 1'b1;
      req_chan.number <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic wait_drained();
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   function automatic number_type random_number();
      number_type value;
      int         d;
      case ($urandom_range(0, 9))
         0, 1, 2: value = number_type'($urandom);
         3: value = number_type'($urandom_range(0, 255));
         4, 5: begin
            // walk up from a random odd value to the next prime: full-length runs
            value = number_type'($urandom | 1);
            while (!prime_flag(value)) value = value + number_type'(2);
         end
         6, 7: begin
            d = int'($urandom_range(2, 255));
            value = number_type'(d * d);
         end
         8: begin
            d = int'($urandom_range(3, 253) | 1);
            value = number_type'(d * (d + 2));
         end
         default: value = number_type'($urandom | 1);
      endcase
      return value;
   endfunction

   task automatic test_small_values();
      for (int n = 0; n <= 9; n++) send_word(number_type'(n));
   endtask

   task automatic test_field_extremes();
      send_word('1);
      send_word(number_type'({NUM_WIDTH{1'b1}} - 1));
      send_word(16'd65521);
      send_word(16'd32768);
      send_word(16'd32749);
      send_word(16'h5555);
      send_word(16'hAAAA);
   endtask

   // squares of prime and composite roots, with the last divisor exactly at the square root, and other composites
   task automatic test_square_bounds();
      send_word(16'd121);
      send_word(16'd221);
      send_word(16'd63001);
      send_word(16'd64009);
      send_word(16'd65025);
      send_word(16'd65279);
   endtask

   task automatic test_back_to_back(input int count);
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      repeat (count) send_word(random_number());
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_word(random_number());
   endtask

   task automatic test_drain_pause(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 10 == 9) begin
            req_chan.valid <= 1'b0;
            burst_left = 0;
            wait_drained();
         end
         send_word(random_number());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.number <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_values();
      test_field_extremes();
      test_square_bounds();
      test_back_to_back(20);
      test_random_mix(67);
      test_drain_pause(30);
      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("prime_trial_division_test: clean");
      end else begin
         $display("prime_trial_division_test: errors");
      end
      $finish;
   end

endmodule

### prime_trial_division.f
rtl/core/ptd_pkg.sv
rtl/core/ptd_req_if.sv
rtl/core/ptd_rsp_if.sv
rtl/core/ptd_rem_unit.sv
rtl/core/prime_trial_division.sv
tb/prime_trial_division_test.sv
